FILE: src/bsls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush stamp line stepper package
// Shared constants, register indexes and control bundles of the stepper.
// ----------------------------------------------------------------------------
package bsls_pkg;

  localparam int MAX_STAMPS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;

  // Width of the draw_step register.
  localparam int STEP_W = 12;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_STEP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ROTATE = 4'd1;

  localparam logic [STEP_W-1:0] DRAW_STEP_RST = 12'd16;

  // Operating modes of the shared compare-subtract unit.
  localparam logic CSU_SQRT = 1'b0;
  localparam logic CSU_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } csu_ctl_t;

  typedef struct packed {
    logic load;
    logic zero;
    logic adv;
  } axis_ctl_t;

endpackage

FILE: src/bsls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush stamp line stepper channels
// Valid/ready channels for segments, stamps and register writes.
// ----------------------------------------------------------------------------
interface bsls_in_if
  import bsls_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] from_x;
  logic signed [COORD_WIDTH-1:0] from_y;
  logic signed [COORD_WIDTH-1:0] to_x;
  logic signed [COORD_WIDTH-1:0] to_y;
  logic                          new_stroke;

  modport source (output valid, from_x, from_y, to_x, to_y, new_stroke, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, new_stroke, output ready);
endinterface

interface bsls_out_if
  import bsls_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] stamp_x;
  logic signed [COORD_WIDTH-1:0] stamp_y;
  logic                          last_stamp;
  logic                          truncated;

  modport source (output valid, stamp_x, stamp_y, last_stamp, truncated, input ready);
  modport sink   (input valid, stamp_x, stamp_y, last_stamp, truncated, output ready);
endinterface

interface bsls_cfg_if
  import bsls_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bsls_csu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// Restoring square root (two bits a cycle) or division (one bit a cycle).
// ----------------------------------------------------------------------------
module bsls_csu
  import bsls_pkg::*;
#(
  parameter int NUM_W = 34,
  parameter int REM_W = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  csu_ctl_t         ctl,
  input  logic [NUM_W-1:0] num,
  input  logic [REM_W-1:0] dvs,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [REM_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quot_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] dvs_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // The root mode shifts in two radicand bits and tries 4q+1; the divide mode
  // shifts in one numerator bit and tries the divisor.
  always_comb begin
    if (mode_r == CSU_SQRT) begin
      rem_sh = {rem_r[REM_W-3:0], num_r[NUM_W-1:NUM_W-2]};
      trial  = {quot_r[REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
      trial  = dvs_r;
    end
    ge = (rem_sh >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(1))) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.mode;
      num_r  <= num;
      dvs_r  <= dvs;
      quot_r <= '0;
      rem_r  <= '0;
      cnt_r  <= (ctl.mode == CSU_SQRT) ? CNT_W'(NUM_W / 2) : CNT_W'(NUM_W);
    end else if (busy_r) begin
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      quot_r <= {quot_r[NUM_W-2:0], ge};
      cnt_r  <= cnt_r - CNT_W'(1);
      if (mode_r == CSU_SQRT) begin
        num_r <= {num_r[NUM_W-3:0], 2'b00};
      end else begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: src/bsls_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stamp axis accumulator
// Tracks floor(|d|*i/seg_len) as quotient and remainder while i advances by
// step.
// ----------------------------------------------------------------------------
module bsls_axis
  import bsls_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  axis_ctl_t                     ctl,
  input  logic signed [COORD_WIDTH-1:0] base,
  input  logic                          neg,
  input  logic [COORD_WIDTH:0]          qstep,
  input  logic [COORD_WIDTH:0]          rstep,
  input  logic [COORD_WIDTH:0]          seg_len,
  output logic signed [COORD_WIDTH-1:0] stamp
);

  localparam int CW = COORD_WIDTH;

  logic [CW:0]   q_r;
  logic [CW:0]   r_r;
  logic [CW+1:0] r_sum;
  logic          wrap;

  // Both remainders stay below seg_len, so one conditional subtract normalizes.
  always_comb begin
    r_sum = {1'b0, r_r} + {1'b0, rstep};
    wrap  = (r_sum >= {1'b0, seg_len});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= ctl.zero ? '0 : qstep;
      r_r <= ctl.zero ? '0 : rstep;
    end else if (ctl.adv) begin
      q_r <= q_r + qstep + (CW+1)'(wrap);
      r_r <= wrap ? (CW+1)'(r_sum - {1'b0, seg_len}) : r_sum[CW:0];
    end
  end

  assign stamp = neg ? (base - $signed(q_r[CW-1:0])) : (base + $signed(q_r[CW-1:0]));

endmodule

FILE: src/brush_stamp_line_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush stamp line stepper core
// Turns stroke segments into evenly spaced brush stamp positions.
// ----------------------------------------------------------------------------
//
//   Port      | Dir | Carries
//   ----------+-----+------------------------------------------------------
//   in_chan   | in  | one segment: from/to point and the new-stroke flag
//   out_chan  | out | one stamp: position, last-of-segment and truncated
//   cfg_chan  | in  | register write: 0 = draw_step, 1 = auto_rotate
//
// A segment first passes through the single compare-subtract unit, which
// computes the distance root and then one divide per axis, one result bit
// per cycle; its stamps then follow one at a time, each only after the sink
// has taken the one before. A stalled sink simply holds the sequencer in
// its wait state. Reset, synchronous and active low, restores draw_step 16,
// auto_rotate 0 and a last stamp point of zero; no clearing pass is needed.
//
module brush_stamp_line_stepper_core
  import bsls_pkg::*;
#(
  parameter int MAX_STAMPS  = MAX_STAMPS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bsls_in_if.sink     in_chan,
  bsls_out_if.source  out_chan,
  bsls_cfg_if.sink    cfg_chan
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int MW    = (CW + 1 > STEP_W) ? CW + 1 : STEP_W;
  localparam int SQ_W  = 2 * CW + 2;
  localparam int DV_W  = CW + 1 + STEP_W;
  localparam int RAW_W = (SQ_W > DV_W) ? SQ_W : DV_W;
  localparam int NUM_W = RAW_W + (RAW_W % 2);
  localparam int REM_W = NUM_W / 2 + 2;
  localparam int IW    = MW + 1;
  localparam int NW    = $clog2(MAX_STAMPS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_RGO   = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIVX  = 4'd7;
  localparam logic [3:0] S_DIVXW = 4'd8;
  localparam logic [3:0] S_DIVY  = 4'd9;
  localparam logic [3:0] S_DIVYW = 4'd10;
  localparam logic [3:0] S_INIT  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [STEP_W-1:0] draw_step_r;
  logic              auto_rot_r;

  // Segment working registers.
  logic signed [CW-1:0] last_x_r, last_y_r;
  logic signed [CW-1:0] base_x_r, base_y_r;
  logic signed [CW-1:0] to_x_r, to_y_r;
  logic                 fresh_r;
  logic [STEP_W-1:0]    step_r;
  logic [DW-1:0]        ad_x_r, ad_y_r;
  logic                 neg_x_r, neg_y_r;
  logic [SQ_W-1:0]      sq_r;
  logic [NUM_W-1:0]     sum_r;
  logic [DW-1:0]        dist_r;
  logic [DW-1:0]        qx_r, rx_r, qy_r, ry_r;
  logic [IW-1:0]        i_r;
  logic [NW-1:0]        n_r;

  // Output register.
  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic                 out_last_r, out_trunc_r;

  logic in_xfer, out_xfer, cfg_xfer;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_valid_r && out_chan.ready;
  assign cfg_xfer = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.stamp_x    = out_x_r;
  assign out_chan.stamp_y    = out_y_r;
  assign out_chan.last_stamp = out_last_r;
  assign out_chan.truncated  = out_trunc_r;

  // A draw_step of zero behaves as one.
  logic [STEP_W-1:0] step_eff;
  assign step_eff = (draw_step_r == '0) ? STEP_W'(1) : draw_step_r;

  // Signed difference to the base point; its magnitude fits in CW bits, the
  // extra bit keeps the sign.
  logic signed [CW:0] dx, dy;
  assign dx = {to_x_r[CW-1], to_x_r} - {base_x_r[CW-1], base_x_r};
  assign dy = {to_y_r[CW-1], to_y_r} - {base_y_r[CW-1], base_y_r};

  // The one multiplier serves both squares and both divide numerators.
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX: begin
        mul_a = MW'(ad_x_r);
        mul_b = MW'(ad_x_r);
      end
      S_SQY: begin
        mul_a = MW'(ad_y_r);
        mul_b = MW'(ad_y_r);
      end
      S_DIVX: begin
        mul_a = MW'(ad_x_r);
        mul_b = MW'(step_r);
      end
      S_DIVY: begin
        mul_a = MW'(ad_y_r);
        mul_b = MW'(step_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Shared root / divide unit.
  csu_ctl_t         csu_ctl;
  logic [NUM_W-1:0] csu_num;
  logic             csu_done;
  logic [NUM_W-1:0] csu_quot;
  logic [REM_W-1:0] csu_rem;

  always_comb begin
    csu_ctl.start = (state_r == S_RGO) || (state_r == S_DIVX) || (state_r == S_DIVY);
    csu_ctl.mode  = (state_r == S_RGO) ? CSU_SQRT : CSU_DIV;
    csu_num       = (state_r == S_RGO) ? sum_r : NUM_W'(prod);
  end

  bsls_csu #(
    .NUM_W (NUM_W),
    .REM_W (REM_W)
  ) u_csu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (csu_ctl),
    .num   (csu_num),
    .dvs   (REM_W'(dist_r)),
    .done  (csu_done),
    .quot  (csu_quot),
    .rem   (csu_rem)
  );

  // Per-axis stamp accumulators.
  axis_ctl_t            axis_ctl;
  logic signed [CW-1:0] stamp_x, stamp_y;

  always_comb begin
    axis_ctl.load = (state_r == S_INIT);
    axis_ctl.zero = fresh_r && !auto_rot_r;
    axis_ctl.adv  = (state_r == S_EMIT);
  end

  bsls_axis #(
    .COORD_WIDTH (CW)
  ) u_axis_x (
    .clk     (clk),
    .ctl     (axis_ctl),
    .base    (base_x_r),
    .neg     (neg_x_r),
    .qstep   (qx_r),
    .rstep   (rx_r),
    .seg_len (dist_r),
    .stamp   (stamp_x)
  );

  bsls_axis #(
    .COORD_WIDTH (CW)
  ) u_axis_y (
    .clk     (clk),
    .ctl     (axis_ctl),
    .base    (base_y_r),
    .neg     (neg_y_r),
    .qstep   (qy_r),
    .rstep   (ry_r),
    .seg_len (dist_r),
    .stamp   (stamp_y)
  );

  // Step bookkeeping for the stamp loop. The segment ends when the next
  // offset passes the segment length or when the stamp budget is spent.
  logic [IW-1:0] i_nxt;
  logic          past_end;
  logic          at_limit;
  logic          short_seg;

  assign i_nxt     = i_r + IW'(step_r);
  assign past_end  = (i_nxt > IW'(dist_r));
  assign at_limit  = (n_r == NW'(MAX_STAMPS - 1));
  assign short_seg = (MW'(dist_r) < MW'(step_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_RGO;
      S_RGO:   state_nxt = S_ROOT;
      S_ROOT:  if (csu_done) state_nxt = S_CHK;
      S_CHK: begin
        if (!short_seg) begin
          state_nxt = S_DIVX;
        end else if (fresh_r && !auto_rot_r) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIVX:  state_nxt = S_DIVXW;
      S_DIVXW: if (csu_done) state_nxt = S_DIVY;
      S_DIVY:  state_nxt = S_DIVYW;
      S_DIVYW: if (csu_done) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_EMIT;
      S_EMIT:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (out_xfer) begin
          state_nxt = out_last_r ? S_IDLE : S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration, the stored last stamp point and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      draw_step_r <= DRAW_STEP_RST;
      auto_rot_r  <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_xfer) begin
        case (cfg_chan.index)
          CFG_DRAW_STEP:   draw_step_r <= cfg_chan.data[STEP_W-1:0];
          CFG_AUTO_ROTATE: auto_rot_r  <= cfg_chan.data[0];
          default:         ;
        endcase
      end

      // A new stroke restarts from its from point, a short new stroke moves on to
      // its to point, and every emitted stamp becomes the new base of the stroke.
      if (in_xfer && in_chan.new_stroke) begin
        last_x_r <= in_chan.from_x;
        last_y_r <= in_chan.from_y;
      end else if (state_r == S_CHK && short_seg && fresh_r) begin
        last_x_r <= to_x_r;
        last_y_r <= to_y_r;
      end else if (state_r == S_EMIT) begin
        last_x_r <= stamp_x;
        last_y_r <= stamp_y;
      end

      if ((state_r == S_CHK && short_seg && fresh_r && !auto_rot_r) ||
          (state_r == S_EMIT)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_x_r <= in_chan.new_stroke ? in_chan.from_x : last_x_r;
      base_y_r <= in_chan.new_stroke ? in_chan.from_y : last_y_r;
      to_x_r   <= in_chan.to_x;
      to_y_r   <= in_chan.to_y;
      fresh_r  <= in_chan.new_stroke;
      step_r   <= step_eff;
    end

    if (state_r == S_DIFF) begin
      ad_x_r  <= dx[CW] ? DW'(-dx) : DW'(dx);
      ad_y_r  <= dy[CW] ? DW'(-dy) : DW'(dy);
      neg_x_r <= dx[CW];
      neg_y_r <= dy[CW];
    end

    if (state_r == S_SQX) begin
      sq_r <= SQ_W'(prod);
    end

    if (state_r == S_SQY) begin
      sum_r <= NUM_W'(sq_r) + NUM_W'(prod);
    end

    if (state_r == S_ROOT && csu_done) begin
      dist_r <= csu_quot[DW-1:0];
    end

    if (state_r == S_DIVXW && csu_done) begin
      qx_r <= csu_quot[DW-1:0];
      rx_r <= csu_rem[DW-1:0];
    end

    if (state_r == S_DIVYW && csu_done) begin
      qy_r <= csu_quot[DW-1:0];
      ry_r <= csu_rem[DW-1:0];
    end

    if (state_r == S_INIT) begin
      i_r <= (fresh_r && !auto_rot_r) ? '0 : IW'(step_r);
      n_r <= '0;
    end else if (state_r == S_EMIT) begin
      i_r <= i_nxt;
      n_r <= n_r + NW'(1);
    end

    // Without auto-rotate, a short new stroke stamps its to point alone.
    if (state_r == S_CHK) begin
      out_x_r     <= to_x_r;
      out_y_r     <= to_y_r;
      out_last_r  <= 1'b1;
      out_trunc_r <= 1'b0;
    end else if (state_r == S_EMIT) begin
      out_x_r     <= stamp_x;
      out_y_r     <= stamp_y;
      out_last_r  <= past_end || at_limit;
      out_trunc_r <= at_limit && !past_end;
    end
  end

endmodule

FILE: sim/bsls_stamp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush stamp line stepper checker
// Watches the segment, stamp and register channels, works out the stamps
// that every accepted segment must produce and compares them in order.
// ----------------------------------------------------------------------------
module bsls_stamp_checker
  import bsls_pkg::*;
#(
  parameter int MAX_STAMPS  = MAX_STAMPS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bsls_in_if   in_mon,
  bsls_out_if  out_mon,
  bsls_cfg_if  cfg_mon,
  output int   fail_count,
  output int   stamps_outstanding
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last_stamp;
    logic   truncated;
  } stamp_t;

  stamp_t            stamps_due[$];
  logic [STEP_W-1:0] step_reg;
  logic              rotate_reg;
  coord_t            pen_x;
  coord_t            pen_y;
  int                mismatches = 0;

  // Integer square root, rounded down, by the digit-by-digit method.
  function automatic longint floor_root(input longint v);
    longint rem;
    longint res;
    longint bitv;
    rem  = v;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - res - bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Point at offset ofs on one axis; the quotient is cut toward zero.
  function automatic longint along_axis(input longint base, input longint d,
                                        input longint ofs, input longint seg_len);
    longint mag;
    mag = ((d < 0) ? -d : d) * ofs / seg_len;
    return (d < 0) ? base - mag : base + mag;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: stamp %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic trace_segment(input coord_t fx, input coord_t fy, input coord_t tx,
                               input coord_t ty, input logic fresh);
    longint bx;
    longint by;
    longint dx;
    longint dy;
    longint seg_len;
    longint stp;
    longint ofs;
    int     n;
    stamp_t s;
    stp = (step_reg == '0) ? 1 : longint'(step_reg);
    if (fresh) begin
      pen_x = fx;
      pen_y = fy;
    end
    bx      = pen_x;
    by      = pen_y;
    dx      = tx - bx;
    dy      = ty - by;
    seg_len = floor_root(dx * dx + dy * dy);
    if (seg_len < stp) begin
      // Short segment: a continuing stroke keeps its pen point.
      if (!fresh) return;
      pen_x = tx;
      pen_y = ty;
      if (rotate_reg) return;
      s = '{x: tx, y: ty, last_stamp: 1'b1, truncated: 1'b0};
      stamps_due.push_back(s);
      return;
    end
    ofs = (fresh && !rotate_reg) ? 0 : stp;
    n   = 0;
    while (ofs <= seg_len && n < MAX_STAMPS) begin
      s.x          = coord_t'(along_axis(bx, dx, ofs, seg_len));
      s.y          = coord_t'(along_axis(by, dy, ofs, seg_len));
      s.last_stamp = 1'b0;
      s.truncated  = 1'b0;
      stamps_due.push_back(s);
      pen_x = s.x;
      pen_y = s.y;
      n++;
      ofs += stp;
    end
    stamps_due[stamps_due.size()-1].last_stamp = 1'b1;
    stamps_due[stamps_due.size()-1].truncated  = (ofs <= seg_len);
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (!rst_n) begin
      step_reg   = DRAW_STEP_RST;
      rotate_reg = 1'b0;
      pen_x      = '0;
      pen_y      = '0;
      stamps_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DRAW_STEP:   step_reg = cfg_mon.data[STEP_W-1:0];
          CFG_AUTO_ROTATE: rotate_reg = cfg_mon.data[0];
          default: ;
        endcase
      end
      // Stamps are compared before a new segment is traced, since a stamp
      // leaving on this edge can only belong to an earlier segment.
      if (out_mon.valid && out_mon.ready) begin
        if (stamps_due.size() == 0) begin
          report_mismatch("with none pending, x", longint'(out_mon.stamp_x), 0);
        end else begin
          want = stamps_due.pop_front();
          if (out_mon.stamp_x !== want.x)
            report_mismatch("x", longint'(out_mon.stamp_x), longint'(want.x));
          if (out_mon.stamp_y !== want.y)
            report_mismatch("y", longint'(out_mon.stamp_y), longint'(want.y));
          if (out_mon.last_stamp !== want.last_stamp)
            report_mismatch("last_stamp", longint'(out_mon.last_stamp), want.last_stamp);
          if (out_mon.truncated !== want.truncated)
            report_mismatch("truncated", longint'(out_mon.truncated), want.truncated);
        end
      end
      if (in_mon.valid && in_mon.ready)
        trace_segment(in_mon.from_x, in_mon.from_y, in_mon.to_x, in_mon.to_y,
                      in_mon.new_stroke);
    end
    fail_count         <= mismatches;
    stamps_outstanding <= stamps_due.size();
  end

endmodule

FILE: sim/brush_stamp_line_stepper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush stamp line stepper testbench
// Drives directed and random stroke segments under several register settings,
// with random gaps on the segment side and random stalls on the stamp side.
// A checker beside the block predicts and compares every stamp.
// ----------------------------------------------------------------------------
module brush_stamp_line_stepper_core_tb;
  import bsls_pkg::*;

  localparam int MAX_STAMPS  = MAX_STAMPS_DEF;
  localparam int COORD_WIDTH = COORD_WIDTH_DEF;

  // A segment that produces nothing gives no sign of when it is done, so
  // every pause before a register write waits well beyond the time the block
  // needs to compute a segment up to its first stamp.
  localparam int SETTLE_CYCLES = 300;

  // Longest correct stretch without any transfer is a settle pause, or a
  // segment's compute time plus a long sender gap and a long sink stall.
  // The limit is that figure taken many times over.
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int RANDOM_PHASES      = 8;
  localparam int SEGMENTS_PER_PHASE = 45;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     stamps_outstanding;
  int     quiet_cycles = 0;

  // Where the current stroke ends as far as the stimulus knows; the random
  // walk continues from here.
  coord_t walk_x;
  coord_t walk_y;
  int     step_now;
  bit     gaps_on;

  bsls_in_if  #(.COORD_WIDTH(COORD_WIDTH)) in_chan ();
  bsls_out_if #(.COORD_WIDTH(COORD_WIDTH)) out_chan ();
  bsls_cfg_if                              cfg_chan ();

  brush_stamp_line_stepper_core #(
    .MAX_STAMPS (MAX_STAMPS),
    .COORD_WIDTH(COORD_WIDTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  bsls_stamp_checker #(
    .MAX_STAMPS (MAX_STAMPS),
    .COORD_WIDTH(COORD_WIDTH)
  ) stamp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_chan),
    .out_mon           (out_chan),
    .cfg_mon           (cfg_chan),
    .fail_count        (fail_count),
    .stamps_outstanding(stamps_outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle stretch length: usually drawn from the short range, now and then from the long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_delta(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // The stamp sink alternates ready bursts and stalls. Some bursts are long,
  // so there are stretches where the block never sees back-pressure. Exactly
  // one assignment happens per falling edge.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      repeat (($urandom_range(0, 99) < 20) ? $urandom_range(50, 300) : $urandom_range(1, 8))
        @(negedge clk) out_chan.ready <= 1'b1;
      repeat (pause_len()) @(negedge clk) out_chan.ready <= 1'b0;
    end
  end

  // Watchdog: a long run of cycles with no transfer on any channel means the
  // block has hung or lost an item.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One segment transfer. An optional gap with valid low comes first; valid
  // is left high afterwards so back-to-back segments need no dead cycle.
  task automatic send_segment(input coord_t fx, input coord_t fy, input coord_t tx,
                              input coord_t ty, input logic fresh);
    int gap;
    gap = (gaps_on && $urandom_range(0, 1) == 1) ? pause_len() : 0;
    repeat (gap) @(negedge clk) in_chan.valid <= 1'b0;
    @(negedge clk);
    in_chan.valid      <= 1'b1;
    in_chan.from_x     <= fx;
    in_chan.from_y     <= fy;
    in_chan.to_x       <= tx;
    in_chan.to_y       <= ty;
    in_chan.new_stroke <= fresh;
    do @(posedge clk); while (!in_chan.ready);
    walk_x = tx;
    walk_y = ty;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk) cfg_chan.valid <= 1'b0;
  endtask

  // Lower the segment valid, wait for every predicted stamp, then give a
  // segment that produced nothing time to finish inside the block.
  task automatic wait_idle();
    @(negedge clk) in_chan.valid <= 1'b0;
    do @(posedge clk); while (stamps_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input int step, input bit rotate);
    wait_idle();
    write_reg(CFG_DRAW_STEP, CFG_DATA_W'(step));
    write_reg(CFG_AUTO_ROTATE, CFG_DATA_W'(rotate));
    step_now = (step == 0) ? 1 : step;
  endtask

  // Random segments are mostly well-formed strokes: a new stroke now and
  // then, followed by continuing segments that walk from the last end point.
  // Walk steps are scaled by the current spacing so that segments give
  // anything from no stamps to a saturated run. A few segments jump to
  // random points anywhere in the coordinate range.
  task automatic random_segment();
    coord_t fx;
    coord_t fy;
    coord_t bx;
    coord_t by;
    coord_t tx;
    coord_t ty;
    logic   fresh;
    int     kind;
    int     span;
    fresh = ($urandom_range(0, 99) < 15);
    // On a continuing stroke the from point is ignored, so it carries noise.
    fx    = coord_t'($urandom);
    fy    = coord_t'($urandom);
    if (fresh && $urandom_range(0, 1) == 1) begin
      fx = walk_x + coord_t'(rand_delta(2000));
      fy = walk_y + coord_t'(rand_delta(2000));
    end
    bx   = fresh ? fx : walk_x;
    by   = fresh ? fy : walk_y;
    kind = $urandom_range(0, 99);
    if (kind < 20) span = step_now / 2;
    else span = (step_now * 12 > 30000) ? 30000 : step_now * 12;
    if (kind >= 88) begin
      tx = coord_t'($urandom);
      ty = coord_t'($urandom);
    end else begin
      tx = bx + coord_t'(rand_delta(span));
      ty = by + coord_t'(rand_delta(span));
    end
    send_segment(fx, fy, tx, ty, fresh);
  endtask

  initial begin
    // Every input of the block is known from time zero.
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.from_x     = '0;
    in_chan.from_y     = '0;
    in_chan.to_x       = '0;
    in_chan.to_y       = '0;
    in_chan.new_stroke = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = CFG_DRAW_STEP;
    cfg_chan.data      = '0;
    walk_x             = '0;
    walk_y             = '0;
    step_now           = int'(DRAW_STEP_RST);
    gaps_on            = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part, first with the reset spacing of 16 and no auto-rotate.
    // A zero-length new stroke stamps its to point.
    send_segment(0, 0, 0, 0, 1'b1);
    // A continuing segment shorter than the spacing produces nothing.
    send_segment(0, 0, 5, 5, 1'b0);
    // Continuing along x and then across both axes from the last stamp.
    send_segment(0, 0, 100, 0, 1'b0);
    send_segment(0, 0, 100, -100, 1'b0);
    // Full-range diagonals saturate at the stamp limit.
    send_segment(-32768, -32768, 32767, 32767, 1'b1);
    send_segment(0, 0, -32768, 32767, 1'b0);
    send_segment(32767, -32768, -32768, 32767, 1'b1);
    // A short new stroke at the top corner.
    send_segment(32767, 32767, 32767, 32767, 1'b1);
    // Negative direction, where the divide is cut toward zero.
    send_segment(0, 0, -20, -21, 1'b1);
    // Exactly the stamp limit with nothing left over, then one offset more.
    send_segment(0, 0, 1008, 0, 1'b1);
    send_segment(0, 0, 1024, 0, 1'b1);

    // Smallest spacing with auto-rotate: a short new stroke gives nothing but
    // still moves the pen, and the first offset is skipped on new strokes.
    set_mode(1, 1'b1);
    send_segment(10, 10, 10, 10, 1'b1);
    send_segment(0, 0, 10, 50, 1'b0);
    send_segment(0, 0, 3, 4, 1'b1);
    send_segment(-32768, 0, 32767, 0, 1'b1);

    // A spacing of zero behaves as one.
    set_mode(0, 1'b0);
    send_segment(0, 0, 7, -7, 1'b1);
    send_segment(0, 0, 7, -7, 1'b0);

    // Largest spacing, with and without auto-rotate.
    set_mode(4095, 1'b1);
    send_segment(-32768, -32768, 32767, 32767, 1'b1);
    send_segment(0, 0, 100, 100, 1'b1);
    send_segment(0, 0, -32768, -32768, 1'b0);
    set_mode(4095, 1'b0);
    send_segment(0, 0, 4095, 0, 1'b1);
    send_segment(0, 0, 4094, 0, 1'b1);

    // Random part, one register setting per phase. Every third phase runs
    // the segment side without gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_mode(16, 1'b0);
        1:       set_mode(1, 1'b1);
        2:       set_mode(4095, 1'b0);
        3:       set_mode($urandom_range(2, 64), 1'b1);
        4:       set_mode(0, 1'b1);
        default: set_mode($urandom_range(1, 300), 1'($urandom_range(0, 1)));
      endcase
      gaps_on = (p % 3 != 1);
      repeat (SEGMENTS_PER_PHASE) random_segment();
    end

    wait_idle();
    if (fail_count == 0 && stamps_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
